>>> sv/resbk_pkg.sv
// ----------------------------------------------------------------------------
// resbk_pkg
// Sizes, types and sequencer states for the record exchange sorter.
// ----------------------------------------------------------------------------
package resbk_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int KEY_BYTES   = 64;

    localparam int IW = $clog2(MAX_RECORDS);              // record index
    localparam int CW = $clog2(MAX_RECORDS + 1);          // record count
    localparam int KW = $clog2(KEY_BYTES);                // key byte position
    localparam int AW = $clog2(MAX_RECORDS * KEY_BYTES);  // key memory address

    // per-record attributes, kept in one memory
    typedef struct packed {
        logic [15:0]   tag;
        logic [5:0]    sector;
        logic [KW-1:0] len;     // stored key bytes; later positions read as zero
    } rec_attr_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_OI_RD,
        S_OI_CAP,
        S_OJ_RD,
        S_OJ_CAP,
        S_CMP_RD,
        S_CMP,
        S_OI_WR,
        S_E_RD,
        S_E_CAP,
        S_E_ATTR,
        S_E_OUT
    } state_t;

endpackage

>>> sv/record_exchange_sort_by_key.sv
// ----------------------------------------------------------------------------
// record_exchange_sort_by_key
// Loads a batch of keyed records and returns them in exchange-sort order.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one surname byte each (key_char). The request with
//   char_last set closes a record and supplies rec_sector and rec_tag; with
//   batch_last also set it closes the batch. in_ready is high while loading,
//   so loading runs at one byte per cycle.
//   After the closing request the block drops in_ready and sorts n records:
//     it builds the index table; each outer pass runs S_OI_RD, S_OI_CAP
//     and S_OI_WR, and each compared pair S_OJ_RD, S_OJ_CAP and b rounds
//     of S_CMP_RD and S_CMP, where b is the number of key bytes scanned (at
//     least 1) by the shared byte comparator, one byte at a time through the
//     key memory ports. Results then leave, each held in an output register
//   until out_ready takes it; a receiver stall simply holds the sequencer.
//   out_last marks the final record; overflow is set on every result of a
//   batch that had too many records or a truncated key.
//   After the final result the block returns to loading.
//   Reset clears counts and flags only; stores need no clearing pass since
//   every entry the sort reads is written during the batch.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_key (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  key_char,
    input  logic [5:0]  rec_sector,
    input  logic [15:0] rec_tag,
    input  logic        char_last,
    input  logic        batch_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_tag,
    output logic [5:0]  out_sector,
    output logic        out_last,
    output logic        overflow
);
    import resbk_pkg::*;

    // ---------------- state ----------------
    state_t        state_reg, state_next;
    logic [CW-1:0] rec_count_reg;     // records in batch, also n during sort
    logic [KW-1:0] char_pos_reg;
    logic          zero_seen_reg;     // a zero byte already ended this key
    logic          ovf_reg;
    logic [IW-1:0] i_reg, j_reg, e_reg;
    logic [KW-1:0] k_reg;             // byte being compared
    logic [IW-1:0] oi_reg, oj_reg;    // index table entries at i and j

    // ---------------- memories ----------------
    logic [7:0]    key_mem  [MAX_RECORDS*KEY_BYTES];
    rec_attr_t     attr_mem [MAX_RECORDS];
    logic [IW-1:0] order_mem[MAX_RECORDS];

    logic          key_we;
    logic [AW-1:0] key_wa, key_ra_a, key_ra_b;
    logic [7:0]    key_wd, key_qa, key_qb;

    logic          attr_we;
    logic [IW-1:0] attr_wa, attr_ra_a, attr_ra_b;
    rec_attr_t     attr_wd, attr_qa, attr_qb;

    logic          order_we;
    logic [IW-1:0] order_wa, order_wd, order_ra, order_q;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        key_qa <= key_mem[key_ra_a];
        key_qb <= key_mem[key_ra_b];
    end

    always_ff @(posedge clk)
    begin
        if (attr_we)
        begin
            attr_mem[attr_wa] <= attr_wd;
        end
        attr_qa <= attr_mem[attr_ra_a];
        attr_qb <= attr_mem[attr_ra_b];
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[order_wa] <= order_wd;
        end
        order_q <= order_mem[order_ra];
    end

    // ---------------- load side ----------------
    logic          in_acc;
    logic          batch_full;
    logic          room;          // key position still storable
    logic [7:0]    ch_eff;
    logic [KW-1:0] pos_after;

    assign in_acc     = in_valid && in_ready;
    assign batch_full = (rec_count_reg == CW'(MAX_RECORDS));
    assign room       = (char_pos_reg < KW'(KEY_BYTES - 1));
    assign ch_eff     = zero_seen_reg ? 8'd0 : key_char;
    assign pos_after  = room ? (char_pos_reg + KW'(1)) : char_pos_reg;

    // ---------------- shared byte comparator ----------------
    logic [7:0] byte_i, byte_j;
    logic       cmp_differ, cmp_done, cmp_swap;

    assign byte_i     = (k_reg < attr_qa.len) ? key_qa : 8'd0;
    assign byte_j     = (k_reg < attr_qb.len) ? key_qb : 8'd0;
    assign cmp_differ = (byte_i != byte_j);
    assign cmp_done   = cmp_differ || (byte_i == 8'd0);
    // record at j moves ahead of record at i
    assign cmp_swap   = cmp_differ ? (byte_j < byte_i) : (attr_qb.sector < attr_qa.sector);

    // loop bounds against n
    logic [CW:0] i_plus1, i_plus2, j_plus1, e_plus1, n_ext;
    logic        more_init, more_j, more_i, e_is_last;

    assign n_ext     = {1'b0, rec_count_reg};
    assign i_plus1   = (CW+1)'(i_reg) + (CW+1)'(1);
    assign i_plus2   = (CW+1)'(i_reg) + (CW+1)'(2);
    assign j_plus1   = (CW+1)'(j_reg) + (CW+1)'(1);
    assign e_plus1   = (CW+1)'(e_reg) + (CW+1)'(1);
    assign more_init = (i_plus1 < n_ext);
    assign more_j    = (j_plus1 < n_ext);
    assign more_i    = (i_plus2 < n_ext);
    assign e_is_last = (e_plus1 == n_ext);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc && char_last && batch_last)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (!more_init)
                begin
                    state_next = (n_ext >= (CW+1)'(2)) ? S_OI_RD : S_E_RD;
                end
            end
            S_OI_RD:  state_next = S_OI_CAP;
            S_OI_CAP: state_next = S_OJ_RD;
            S_OJ_RD:  state_next = S_OJ_CAP;
            S_OJ_CAP: state_next = S_CMP_RD;
            S_CMP_RD: state_next = S_CMP;
            S_CMP:
            begin
                if (!cmp_done)
                begin
                    state_next = S_CMP_RD;
                end
                else
                begin
                    state_next = more_j ? S_OJ_RD : S_OI_WR;
                end
            end
            S_OI_WR:  state_next = more_i ? S_OI_RD : S_E_RD;
            S_E_RD:   state_next = S_E_CAP;
            S_E_CAP:  state_next = S_E_ATTR;
            S_E_ATTR: state_next = S_E_OUT;
            S_E_OUT:
            begin
                if (out_ready)
                begin
                    state_next = out_last ? S_LOAD : S_E_RD;
                end
            end
            default:  state_next = S_LOAD;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        key_we    = 1'b0;
        key_wa    = AW'(rec_count_reg[IW-1:0]) * AW'(KEY_BYTES) + AW'(char_pos_reg);
        key_wd    = ch_eff;
        key_ra_a  = AW'(oi_reg) * AW'(KEY_BYTES) + AW'(k_reg);
        key_ra_b  = AW'(oj_reg) * AW'(KEY_BYTES) + AW'(k_reg);
        attr_we   = 1'b0;
        attr_wa   = rec_count_reg[IW-1:0];
        attr_wd   = '{tag: rec_tag, sector: rec_sector, len: pos_after};
        attr_ra_a = oi_reg;
        attr_ra_b = oj_reg;
        order_we  = 1'b0;
        order_wa  = i_reg;
        order_wd  = oi_reg;
        order_ra  = i_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                key_we   = in_acc && !batch_full && room;
                attr_we  = in_acc && !batch_full && char_last;
            end
            S_INIT:
            begin
                order_we = 1'b1;
                order_wd = i_reg;
            end
            S_OJ_RD:  order_ra = j_reg;
            S_CMP:
            begin
                order_we = cmp_done && cmp_swap;
                order_wa = j_reg;
            end
            S_OI_WR:  order_we = 1'b1;
            S_E_RD:   order_ra = e_reg;
            S_E_CAP:  attr_ra_a = order_q;
            S_E_OUT:  out_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            rec_count_reg <= '0;
            char_pos_reg  <= '0;
            zero_seen_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            e_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (char_last)
                        begin
                            if (!batch_full)
                            begin
                                rec_count_reg <= rec_count_reg + CW'(1);
                            end
                            // record dropped, or its closing byte truncated
                            if (batch_full || (!room && ch_eff != 8'd0))
                            begin
                                ovf_reg <= 1'b1;
                            end
                            char_pos_reg  <= '0;
                            zero_seen_reg <= 1'b0;
                            i_reg         <= '0;
                        end
                        else if (!batch_full)
                        begin
                            if (room)
                            begin
                                char_pos_reg <= pos_after;
                                if (ch_eff == 8'd0)
                                begin
                                    zero_seen_reg <= 1'b1;
                                end
                            end
                            else if (ch_eff != 8'd0)
                            begin
                                ovf_reg <= 1'b1;   // key truncated
                            end
                        end
                    end
                end
                S_INIT:
                begin
                    if (more_init)
                    begin
                        i_reg <= i_reg + IW'(1);
                    end
                    else
                    begin
                        i_reg <= '0;
                        j_reg <= IW'(1);
                        e_reg <= '0;
                    end
                end
                S_OJ_RD:  k_reg <= '0;
                S_CMP:
                begin
                    if (!cmp_done)
                    begin
                        k_reg <= k_reg + KW'(1);
                    end
                    else if (more_j)
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                S_OI_WR:
                begin
                    i_reg <= i_reg + IW'(1);
                    j_reg <= IW'(i_plus2);
                    e_reg <= '0;
                end
                S_E_OUT:
                begin
                    if (out_ready)
                    begin
                        if (out_last)
                        begin
                            rec_count_reg <= '0;
                            char_pos_reg  <= '0;
                            zero_seen_reg <= 1'b0;
                            ovf_reg       <= 1'b0;
                        end
                        else
                        begin
                            e_reg <= e_reg + IW'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OI_CAP)
        begin
            oi_reg <= order_q;
        end
        if (state_reg == S_OJ_CAP)
        begin
            oj_reg <= order_q;
        end
        if (state_reg == S_CMP && cmp_done && cmp_swap)
        begin
            oi_reg <= oj_reg;
        end
        if (state_reg == S_E_ATTR)
        begin
            out_tag    <= attr_qa.tag;
            out_sector <= attr_qa.sector;
            out_last   <= e_is_last;
            overflow   <= ovf_reg;
        end
    end

    // ---------------- assertions ----------------
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("load and result requests overlap");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rec_count_reg <= CW'(MAX_RECORDS))
        else $error("record count beyond capacity");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_pos_reg <= KW'(KEY_BYTES - 1))
        else $error("key position beyond key length");

    a_batch_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last)
        |=> (state_reg == S_LOAD && rec_count_reg == '0 && !ovf_reg))
        else $error("batch not cleared after last result");

    a_sort_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> (rec_count_reg != '0))
        else $error("sort started on empty batch");

endmodule

>>> dv/record_exchange_sort_by_key_tb.sv
// ----------------------------------------------------------------------------
// record_exchange_sort_by_key_tb
// Self-checking bench for the record exchange sorter. Surname-byte requests
// stream in with random gaps. A local model of the batch works out the
// sorted order of each batch. Every result is checked against that order
// while the result side stalls at random.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_key_tb;
    import resbk_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_GAP      = 12;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_REQS  = 40;
    localparam int PRINT_CAP    = 40;

    // one load request as the driver presents it, plus its lead-in gap
    typedef struct {
        logic [7:0]  key_char;
        logic [5:0]  sector;
        logic [15:0] tag;
        logic        char_last;
        logic        batch_last;
        int          gap;
    } byte_req_t;

    // one record as it should leave the sorter
    typedef struct {
        logic [15:0] tag;
        logic [5:0]  sector;
        logic        last;
        logic        ovf;
    } sorted_rec_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  key_char   = 8'd0;
    logic [5:0]  rec_sector = 6'd0;
    logic [15:0] rec_tag    = 16'd0;
    logic        char_last  = 1'b0;
    logic        batch_last = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [15:0] out_tag;
    logic [5:0]  out_sector;
    logic        out_last;
    logic        overflow;

    record_exchange_sort_by_key dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_char   (key_char),
        .rec_sector (rec_sector),
        .rec_tag    (rec_tag),
        .char_last  (char_last),
        .batch_last (batch_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_tag    (out_tag),
        .out_sector (out_sector),
        .out_last   (out_last),
        .overflow   (overflow)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    byte_req_t   byte_req_q [$];     // requests waiting to be driven
    sorted_rec_t sorted_q [$];       // results still owed by the sorter
    logic [7:0]  key_buf [$];        // scratch key for queue_record

    int cycle_cnt     = 0;
    int err_cnt       = 0;
    int reqs_sent     = 0;
    int checked_cnt   = 0;
    int batch_cnt     = 0;
    int ovf_batch_cnt = 0;
    int gap_hi        = 0;

    // Model of the batch in flight. Stores keep old contents across batches,
    // but every entry the sort reads is rewritten within the batch.
    logic [7:0]  key_mem [MAX_RECORDS][KEY_BYTES];
    logic [5:0]  sector_mem [MAX_RECORDS];
    logic [15:0] tag_mem [MAX_RECORDS];
    int          rec_cnt       = 0;
    int          key_pos       = 0;
    bit          trunc_or_full = 1'b0;

    task automatic flag_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    endtask

    // record a goes ahead of record b: byte-wise key order, then sector
    function automatic bit sorts_ahead(input int a, input int b);
        for (int k = 0; k < KEY_BYTES; k++)
        begin
            if (key_mem[a][k] != key_mem[b][k])
                return key_mem[a][k] < key_mem[b][k];
            if (key_mem[a][k] == 8'd0)
                break;
        end
        return sector_mem[a] < sector_mem[b];
    endfunction

    // Fold one accepted request into the model; on batch end, run the
    // exchange sort with the same i/j visiting order and queue the results.
    task automatic apply_request(input byte_req_t r);
        logic [7:0]  ch;
        int          order [MAX_RECORDS];
        int          swap;
        sorted_rec_t rec;
        ch = r.key_char;
        if (rec_cnt < MAX_RECORDS)
        begin
            // once a zero is stored, the rest of the key reads as zero
            if (key_pos > 0 && key_mem[rec_cnt][key_pos - 1] == 8'd0)
                ch = 8'd0;
            if (key_pos < KEY_BYTES - 1)
            begin
                key_mem[rec_cnt][key_pos] = ch;
                key_pos++;
            end
            else if (ch != 8'd0)
            begin
                trunc_or_full = 1'b1;   // truncated key
            end
        end
        if (!r.char_last)
            return;
        if (rec_cnt < MAX_RECORDS)
        begin
            for (int k = key_pos; k < KEY_BYTES; k++)
                key_mem[rec_cnt][k] = 8'd0;
            sector_mem[rec_cnt] = r.sector;
            tag_mem[rec_cnt]    = r.tag;
            rec_cnt++;
        end
        else
        begin
            trunc_or_full = 1'b1;       // record dropped, batch full
        end
        key_pos = 0;
        if (!r.batch_last)
            return;
        for (int i = 0; i < rec_cnt; i++)
            order[i] = i;
        for (int i = 0; i + 1 < rec_cnt; i++)
        begin
            for (int j = i + 1; j < rec_cnt; j++)
            begin
                if (sorts_ahead(order[j], order[i]))
                begin
                    swap     = order[i];
                    order[i] = order[j];
                    order[j] = swap;
                end
            end
        end
        for (int i = 0; i < rec_cnt; i++)
        begin
            rec.tag    = tag_mem[order[i]];
            rec.sector = sector_mem[order[i]];
            rec.last   = (i == rec_cnt - 1);
            rec.ovf    = trunc_or_full;
            sorted_q.push_back(rec);
        end
        batch_cnt++;
        if (trunc_or_full)
            ovf_batch_cnt++;
        rec_cnt       = 0;
        key_pos       = 0;
        trunc_or_full = 1'b0;
    endtask

    task automatic check_result();
        sorted_rec_t want;
        if (sorted_q.size() == 0)
        begin
            flag_mismatch($sformatf("result with nothing pending: tag %h sector %0d",
                                    out_tag, out_sector));
            return;
        end
        want = sorted_q.pop_front();
        checked_cnt++;
        if (out_tag !== want.tag)
            flag_mismatch($sformatf("out_tag %h, want %h", out_tag, want.tag));
        if (out_sector !== want.sector)
            flag_mismatch($sformatf("out_sector %0d, want %0d", out_sector, want.sector));
        if (out_last !== want.last)
            flag_mismatch($sformatf("out_last %b, want %b", out_last, want.last));
        if (overflow !== want.ovf)
            flag_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    // Split key_buf into one request per byte. Bytes before the last carry
    // junk sector/tag the block must ignore, and now and then a lone
    // batch_last; 'lone' forces batch_last onto all of them.
    task automatic queue_record(input logic [5:0] sec, input logic [15:0] tg,
                                input bit blast, input bit lone);
        byte_req_t r;
        for (int k = 0; k < key_buf.size(); k++)
        begin
            r.key_char   = key_buf[k];
            r.char_last  = (k == key_buf.size() - 1);
            r.batch_last = r.char_last ? blast : (lone || $urandom_range(0, 9) == 0);
            r.sector     = r.char_last ? sec : 6'($urandom_range(0, 63));
            r.tag        = r.char_last ? tg : 16'($urandom_range(0, 65535));
            r.gap        = $urandom_range(0, gap_hi);
            byte_req_q.push_back(r);
        end
        key_buf.delete();
    endtask

    // narrow alphabet so equal keys and shared prefixes are common
    function automatic logic [7:0] pick_key_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(0, 255));
            default: return 8'h41 + 8'($urandom_range(0, 2));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: one request at a time from byte_req_q, gap drawn per request.
    // A gap of zero keeps in_valid high straight into the next request.
    // ------------------------------------------------------------------
    byte_req_t cur_req;
    int        load_wait = 0;
    bit        load_show;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            key_char   <= 8'd0;
            rec_sector <= 6'd0;
            rec_tag    <= 16'd0;
            char_last  <= 1'b0;
            batch_last <= 1'b0;
            load_wait  = 0;
        end
        else
        begin
            load_show = in_valid;
            if (in_valid && in_ready)
            begin
                apply_request(cur_req);
                reqs_sent++;
                load_show = 1'b0;
            end
            if (!load_show && byte_req_q.size() > 0)
            begin
                if (load_wait < byte_req_q[0].gap)
                begin
                    load_wait++;
                end
                else
                begin
                    cur_req    = byte_req_q.pop_front();
                    load_wait  = 0;
                    load_show  = 1'b1;
                    key_char   <= cur_req.key_char;
                    rec_sector <= cur_req.sector;
                    rec_tag    <= cur_req.tag;
                    char_last  <= cur_req.char_last;
                    batch_last <= cur_req.batch_last;
                end
            end
            in_valid <= load_show;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken result, then stalls out_ready for a drawn
    // number of cycles. drain_fast flips now and then for stall-free runs.
    // ------------------------------------------------------------------
    int drain_wait = 0;
    bit drain_fast = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            drain_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result();
                if ($urandom_range(0, 15) == 0)
                    drain_fast = !drain_fast;
                drain_wait = drain_fast ? 0 : $urandom_range(0, MAX_GAP);
            end
            out_ready <= (drain_wait == 0);
            if (drain_wait > 0)
                drain_wait--;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          n_recs;
        int          key_len;
        int          rand_base;
        logic [7:0]  long_key [$];

        // Directed batch: byte and field extremes, zero first byte, zero in
        // mid key, keys equal after termination (sector tie-break, and one
        // full tie that must keep arrival order), prefix ordering.
        gap_hi = 0;
        key_buf = '{8'hFF};              queue_record(6'd63, 16'hFFFF, 1'b0, 1'b0);
        key_buf = '{8'h00};              queue_record(6'd0, 16'h0000, 1'b0, 1'b0);
        key_buf = '{8'h01, 8'h00, 8'h41}; queue_record(6'd5, 16'h1111, 1'b0, 1'b0);
        key_buf = '{8'h01};              queue_record(6'd5, 16'h2222, 1'b0, 1'b0);
        key_buf = '{8'h01};              queue_record(6'd4, 16'h3333, 1'b0, 1'b0);
        key_buf = '{8'h41, 8'h42};       queue_record(6'd42, 16'hA5A5, 1'b0, 1'b0);
        key_buf = '{8'h41};              queue_record(6'd21, 16'h5A5A, 1'b1, 1'b0);

        // single-record batch whose leading bytes all carry a lone batch_last
        gap_hi = MAX_GAP;
        key_buf = '{8'h80, 8'h7F, 8'h55}; queue_record(6'd32, 16'h8001, 1'b1, 1'b1);

        // two-record batch, high/low bit patterns
        key_buf = '{8'h7F, 8'h80};       queue_record(6'd31, 16'h7FFE, 1'b0, 1'b0);
        key_buf = '{8'h7F, 8'h7F};       queue_record(6'd62, 16'h0001, 1'b1, 1'b0);

        // Long keys: 63 stored bytes then a zero fits exactly; the same 63
        // bytes followed by more nonzero bytes truncate and flag overflow,
        // leaving two equal keys split by sector.
        gap_hi = 0;
        for (int k = 0; k < KEY_BYTES - 1; k++)
            long_key.push_back(8'(8'h41 + (k % 7)));
        key_buf = long_key;
        key_buf.push_back(8'h00);
        queue_record(6'd9, 16'hC0DE, 1'b0, 1'b0);
        key_buf = long_key;
        key_buf.push_back(8'h5A);
        key_buf.push_back(8'h5B);
        queue_record(6'd2, 16'hBEEF, 1'b1, 1'b0);

        // Full batch: MAX_RECORDS records, then one more multi-byte record
        // whose bytes are ignored and which is dropped, then a dropped
        // closing record.
        gap_hi = 3;
        for (int i = 0; i < MAX_RECORDS; i++)
        begin
            key_buf.push_back(pick_key_byte());
            queue_record(6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)),
                         1'b0, 1'b0);
        end
        key_buf = '{8'h20, 8'h21, 8'h22};
        queue_record(6'd1, 16'hDEAD, 1'b0, 1'b0);
        key_buf = '{8'h01};
        queue_record(6'd1, 16'hFACE, 1'b1, 1'b0);

        // Random batches: mostly small, a few larger; bursty or gappy.
        rand_base = byte_req_q.size();
        while (byte_req_q.size() < rand_base + RANDOM_REQS)
        begin
            gap_hi = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            n_recs = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 8);
            for (int i = 0; i < n_recs; i++)
            begin
                key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14)
                                                      : $urandom_range(1, 5);
                for (int k = 0; k < key_len; k++)
                    key_buf.push_back(pick_key_byte());
                queue_record(6'($urandom_range(0, 1) ? $urandom_range(3, 4)
                                                     : $urandom_range(0, 63)),
                             16'($urandom_range(0, 65535)), i == n_recs - 1, 1'b0);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge, clear of the clocked blocks
        while (byte_req_q.size() != 0 || in_valid || sorted_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d load requests over %0d batches (%0d with overflow).",
                 reqs_sent, batch_cnt, ovf_batch_cnt);
        $display("Checked %0d sorted records, %0d mismatches.", checked_cnt, err_cnt);
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
